@@ sv/multi_round_discovery_terminator_core_defines.svh @@
// ----------------------------------------------------------------------------
// Discovery terminator assertion macros
// Shorthand for concurrent assertions on the core's clock and reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_ROUND_DISCOVERY_TERMINATOR_CORE_DEFINES_SVH
`define MULTI_ROUND_DISCOVERY_TERMINATOR_CORE_DEFINES_SVH

// Generic form with an explicit clock and active-low reset.
`define MRDT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Form bound to the core's own clock and reset names.
`define MRDT_ASSERT_CORE(lbl, prop, msg) \
  `MRDT_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ sv/mrdt_pkg.sv @@
// ----------------------------------------------------------------------------
// Discovery terminator package
// Widths, codes, interface structs and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrdt_pkg;

  localparam int MaxWindow  = 16;
  localparam int CntBits    = 24;
  localparam int ThBits     = 17;
  localparam int FracBits   = 16;
  localparam int WinCfgBits = 5;
  localparam int CfgDataBits = ThBits;
  localparam int CfgIdxBits = 2;
  localparam int ActBits    = 2;
  localparam int MdBits     = 8;

  localparam int FillBits = $clog2(MaxWindow + 1);
  localparam int IdxBits  = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int SumBits  = CntBits + $clog2(MaxWindow);

  typedef enum logic [ActBits-1:0] {
    ACT_DATA  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_START = 2'd2
  } action_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_MULTI_ROUND = 2'd0,
    CFG_ROUND_TH    = 2'd1,
    CFG_DISC_TH     = 2'd2,
    CFG_WINDOW      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic push;
    logic clear;
  } win_ctrl_t;

  typedef struct packed {
    logic [SumBits-1:0] sum_next;
    logic               full_next;
  } win_stat_t;

  // Packed so that send_request lands in bit 0.
  typedef struct packed {
    logic discovery_finished;
    logic round_finished;
    logic active;
    logic send_request;
  } result_t;

  function automatic logic [CntBits-1:0] sat_add(logic [CntBits-1:0] a,
                                                 logic [CntBits-1:0] b);
    logic [CntBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntBits] ? {CntBits{1'b1}} : s[CntBits-1:0];
  endfunction

  function automatic logic [FillBits-1:0] clamp_size(logic [WinCfgBits-1:0] c);
    logic [FillBits+WinCfgBits-1:0] cw;
    cw = {{FillBits{1'b0}}, c};
    if (cw == '0) begin
      return FillBits'(1);
    end else if (cw > (FillBits + WinCfgBits)'(MaxWindow)) begin
      return FillBits'(MaxWindow);
    end
    return cw[FillBits-1:0];
  endfunction

endpackage

@@ sv/mrdt_cell.sv @@
// ----------------------------------------------------------------------------
// Window cell
// Holds one slot count and hands it to the next cell on every push.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrdt_cell import mrdt_pkg::*; (
  input  logic               clk_i,
  input  logic               shift_i,
  input  logic [CntBits-1:0] data_i,
  output logic [CntBits-1:0] data_o
);

  logic [CntBits-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      count_q <= data_i;
    end
  end

  assign data_o = count_q;

endmodule

@@ sv/mrdt_window.sv @@
// ----------------------------------------------------------------------------
// Sliding slot window
// A row of cells shifted on each slot tick, with fill count and running sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrdt_window import mrdt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  win_ctrl_t           ctrl_i,
  input  logic [CntBits-1:0]  slot_count_i,
  input  logic [FillBits-1:0] size_i,
  output win_stat_t           stat_o
);

  logic [CntBits-1:0]  tap [MaxWindow];
  logic [FillBits-1:0] fill_q, fill_d;
  logic [SumBits-1:0]  sum_q, sum_d;
  logic                drop;
  logic [FillBits-1:0] oldest_pos;
  logic [IdxBits-1:0]  oldest_idx;

  // Cell 0 holds the newest slot, cell k the slot pushed k ticks ago.
  for (genvar k = 0; k < MaxWindow; k++) begin : g_cell
    if (k == 0) begin : g_first
      mrdt_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(ctrl_i.push),
        .data_i (slot_count_i),
        .data_o (tap[k])
      );
    end else begin : g_next
      mrdt_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(ctrl_i.push),
        .data_i (tap[k-1]),
        .data_o (tap[k])
      );
    end
  end

  always_comb begin
    drop       = (fill_q >= size_i) && (fill_q != '0);
    oldest_pos = fill_q - FillBits'(1);
    oldest_idx = oldest_pos[IdxBits-1:0];
    sum_d      = sum_q - (drop ? SumBits'(tap[oldest_idx]) : '0) + SumBits'(slot_count_i);
    fill_d     = fill_q - FillBits'(drop) + FillBits'(1);
  end

  assign stat_o.sum_next  = sum_d;
  assign stat_o.full_next = (fill_d == size_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
    end else if (ctrl_i.clear) begin
      fill_q <= '0;
      sum_q  <= '0;
    end else if (ctrl_i.push) begin
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

endmodule

@@ sv/multi_round_discovery_terminator_core.sv @@
// A result beat is registered into the output buffer when its event beat is taken.
// Throughput: one event per cycle; the round and discovery tests each use one
// 17x24 multiply and compare in the accept cycle, next to the window's cell row.
// A two-entry output buffer keeps input open while one result waits; two stall it.
// Reset (rst_ni low, asynchronous) empties the window, zeroes all counters,
// leaves discovery idle and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// Multi-round discovery terminator core
// Counts discovery traffic per slot and decides when rounds and discovery end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_round_discovery_terminator_core import mrdt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [7:0] new_metadata_count
  input  logic [1:0]             s_axis_tuser,  // [1:0] action
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] send_request, [1] active, [2] round_finished, [3] discovery_finished,
  // [7:4] zero
  output logic [7:0]             m_axis_tdata
);

  logic                mre_q;
  logic [ThBits-1:0]   thr_q, thd_q;
  logic [WinCfgBits-1:0] win_q;

  logic [CntBits-1:0]  smsg_q, smsg_d;
  logic [CntBits-1:0]  rmsg_q, rmsg_d;
  logic [CntBits-1:0]  rmd_q, rmd_d;
  logic [CntBits-1:0]  dmd_q, dmd_d;
  logic                run_q, run_d;

  result_t             res;
  result_t             out0_q, out1_q;
  logic                v0_q, v1_q;

  win_ctrl_t           wctrl;
  win_stat_t           wstat;
  logic [FillBits-1:0] wsize;

  logic                s_fire, m_fire;
  logic [MdBits-1:0]   newmd;
  logic [ThBits+CntBits-1:0]  rprod, dprod;
  logic [SumBits+ThBits-1:0]  rlhs;
  logic [CntBits+ThBits-1:0]  dlhs;
  logic                round_end, disc_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mre_q <= 1'b1;
      thr_q <= '0;
      thd_q <= '0;
      win_q <= WinCfgBits'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MULTI_ROUND: mre_q <= cfg_data_i[0];
        CFG_ROUND_TH:    thr_q <= cfg_data_i[ThBits-1:0];
        CFG_DISC_TH:     thd_q <= cfg_data_i[ThBits-1:0];
        CFG_WINDOW:      win_q <= cfg_data_i[WinCfgBits-1:0];
        default: ;
      endcase
    end
  end

  assign wsize  = clamp_size(win_q);
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign newmd  = s_axis_tdata[MdBits-1:0];

  mrdt_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (wctrl),
    .slot_count_i(smsg_q),
    .size_i      (wsize),
    .stat_o      (wstat)
  );

  // Ratios compared by cross-multiplication: sum/msgs <= TH as sum*2^16 <= TH*msgs.
  always_comb begin
    rprod     = (ThBits + CntBits)'(thr_q) * (ThBits + CntBits)'(rmsg_q);
    dprod     = (ThBits + CntBits)'(thd_q) * (ThBits + CntBits)'(dmd_q);
    rlhs      = (SumBits + ThBits)'({wstat.sum_next, {FracBits{1'b0}}});
    dlhs      = (CntBits + ThBits)'({rmd_q, {FracBits{1'b0}}});
    round_end = wstat.full_next &&
                ((wstat.sum_next == '0) || (rlhs <= (SumBits + ThBits)'(rprod)));
    disc_end  = (rmd_q == '0) || (dlhs <= dprod);
  end

  always_comb begin
    smsg_d = smsg_q;
    rmsg_d = rmsg_q;
    rmd_d  = rmd_q;
    dmd_d  = dmd_q;
    run_d  = run_q;
    wctrl  = '0;
    res    = '0;
    if (s_fire) begin
      unique case (action_e'(s_axis_tuser))
        ACT_START: begin
          res.send_request = 1'b1;
          if (mre_q) begin
            dmd_d       = '0;
            rmd_d       = '0;
            rmsg_d      = '0;
            smsg_d      = '0;
            wctrl.clear = 1'b1;
            run_d       = 1'b1;
          end else begin
            run_d = 1'b0;
          end
        end
        ACT_DATA: begin
          dmd_d  = sat_add(dmd_q, CntBits'(newmd));
          rmd_d  = sat_add(rmd_q, CntBits'(newmd));
          rmsg_d = sat_add(rmsg_q, CntBits'(1));
          smsg_d = sat_add(smsg_q, CntBits'(1));
        end
        ACT_TICK: begin
          if (run_q) begin
            wctrl.push = 1'b1;
            if (round_end) begin
              res.round_finished = 1'b1;
              if (disc_end) begin
                res.discovery_finished = 1'b1;
                run_d = 1'b0;
              end else begin
                rmd_d            = '0;
                rmsg_d           = '0;
                smsg_d           = '0;
                wctrl.clear      = 1'b1;
                res.send_request = 1'b1;
              end
            end else begin
              smsg_d = '0;
            end
          end
        end
        default: ;
      endcase
    end
    res.active = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smsg_q <= '0;
      rmsg_q <= '0;
      rmd_q  <= '0;
      dmd_q  <= '0;
      run_q  <= 1'b0;
    end else begin
      smsg_q <= smsg_d;
      rmsg_q <= rmsg_d;
      rmd_q  <= rmd_d;
      dmd_q  <= dmd_d;
      run_q  <= run_d;
    end
  end

  // Two-entry result buffer: out0 is the beat on offer, out1 the one behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (m_fire) begin
      if (v1_q) begin
        v0_q <= 1'b1;
        v1_q <= 1'b0;
      end else begin
        v0_q <= s_fire;
      end
    end else if (s_fire) begin
      if (v0_q) begin
        v1_q <= 1'b1;
      end else begin
        v0_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_fire) begin
      out0_q <= v1_q ? out1_q : res;
    end else if (s_fire) begin
      if (v0_q) begin
        out1_q <= res;
      end else begin
        out0_q <= res;
      end
    end
  end

  assign s_axis_tready = !v1_q;
  assign m_axis_tvalid = v0_q;
  assign m_axis_tdata  = {4'b0000, out0_q};

endmodule

@@ sv/mrdt_checker.sv @@
// ----------------------------------------------------------------------------
// Discovery terminator port checker
// Watches the result stream for handshake and outcome consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_round_discovery_terminator_core_defines.svh"

module mrdt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic       out_stall;
  logic       disc_beat;
  logic       new_round_beat;
  logic [3:0] flags;
  logic [1:0] req_act;

  assign flags          = m_axis_tdata[3:0];
  assign req_act        = m_axis_tdata[1:0];
  assign out_stall      = m_axis_tvalid && !m_axis_tready;
  assign disc_beat      = m_axis_tvalid && flags[3];
  assign new_round_beat = m_axis_tvalid && flags[2] && !flags[3];

  `MRDT_ASSERT_CORE(a_out_hold, out_stall |=> m_axis_tvalid, "result beat dropped in stall")
  `MRDT_ASSERT_CORE(a_out_stable, out_stall |=> $stable(m_axis_tdata), "stalled beat changed")
  // Discovery can only end together with the round that ends it.
  `MRDT_ASSERT_CORE(a_disc_needs_round, disc_beat |-> flags[2], "disc end without round end")
  // Once discovery ends, slot handling stops.
  `MRDT_ASSERT_CORE(a_disc_idle, disc_beat |-> req_act == 2'b00, "active after disc end")
  // A round that ends without ending discovery opens a new one with a request.
  `MRDT_ASSERT_CORE(a_new_round_req, new_round_beat |-> &req_act, "new round without request")

endmodule

bind multi_round_discovery_terminator_core mrdt_checker u_mrdt_checker (.*);
